FILE: rtl/core/sdhf_pkg.sv
// Shared constants, types and arithmetic helpers for the height-field step block.
package sdhf_pkg;

    // Grid geometry
    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int NODES      = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W     = $clog2(NODES);
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int FIRST_NODE = GRID_COLS + 1;
    localparam int LAST_NODE  = (GRID_ROWS - 2) * GRID_COLS + GRID_COLS - 2;

    // Operation codes
    localparam logic [1:0] OP_POKE = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_HEIGHT_GAIN  = 2'd0;
    localparam logic [1:0] REG_RESTORE_GAIN = 2'd1;
    localparam logic [1:0] REG_DAMPING_GAIN = 2'd2;
    localparam logic [1:0] REG_UPDATE_GAIN  = 2'd3;

    // Register reset values (Q4.12)
    localparam logic signed [15:0] RST_HEIGHT_GAIN  = 16'sd410;
    localparam logic signed [15:0] RST_RESTORE_GAIN = 16'sd41;
    localparam logic signed [15:0] RST_DAMPING_GAIN = 16'sd205;
    localparam logic signed [15:0] RST_UPDATE_GAIN  = 16'sd4096;

    typedef struct packed {
        logic signed [15:0] hg;
        logic signed [15:0] rg;
        logic signed [15:0] dg;
        logic signed [15:0] ug;
    } t_gains;

    // Controller to datapath commands
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic              in_cap;
        logic              d_en;
        logic              d_center;
        logic              m_en;
        logic              a_en;
        logic              a_clr;
        logic              dw_en;
        logic              u_mul;
        logic              u_vel;
        logic              u_wr;
        logic              pk_wr;
        logic              clr_wr;
    } t_dp_cmd;

    // Controller status toward the result register
    typedef struct packed {
        logic done;
        logic rd_ok;
    } t_ctrl_ev;

    // Saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] res;
        if (x[47:31] == '0 || x[47:31] == '1) begin
            res = x[31:0];
        end else if (x[47]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

    // Divide by 4096, rounding half away from zero
    function automatic logic signed [36:0] rnd12(input logic signed [48:0] p);
        logic signed [49:0] s;
        s = 50'(p) + (p[48] ? 50'sd2047 : 50'sd2048);
        return s[48:12];
    endfunction

endpackage

FILE: rtl/core/sdhf_dp.sv
// Datapath: node memories, difference/multiply/accumulate stages and update arithmetic.
module sdhf_dp import sdhf_pkg::*; (
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    input  t_gains             i_gains,
    input  logic signed [31:0] i_amount,
    output logic signed [31:0] o_rd_h,
    output logic signed [31:0] o_rd_v
);

    logic signed [31:0] mem_h [NODES];
    logic signed [31:0] mem_v [NODES];
    logic signed [31:0] mem_d [NODES];

    logic signed [31:0] r_rd_h, r_rd_v, r_rd_d;
    logic signed [31:0] r_hc, r_vc, r_amt, r_vn;
    logic signed [32:0] r_dh, r_dv;
    logic               r_dc;
    logic signed [48:0] r_ph, r_pv;
    logic signed [41:0] r_acc;
    logic signed [47:0] r_pd;

    logic signed [41:0] w_term;
    logic signed [31:0] w_hn, w_vpoke;

    assign w_term  = 42'(rnd12(r_ph)) + 42'(rnd12(r_pv));
    assign w_hn    = sat32(48'(r_hc) + 48'(r_vn));
    assign w_vpoke = sat32(48'(r_rd_v) + 48'(r_amt));

    // Height memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem_h[i_cmd.wr_addr] <= '0;
        end else if (i_cmd.u_wr) begin
            mem_h[i_cmd.wr_addr] <= w_hn;
        end
        if (i_cmd.rd_en) begin
            r_rd_h <= mem_h[i_cmd.rd_addr];
        end
    end

    // Velocity memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem_v[i_cmd.wr_addr] <= '0;
        end else if (i_cmd.u_wr) begin
            mem_v[i_cmd.wr_addr] <= r_vn;
        end else if (i_cmd.pk_wr) begin
            mem_v[i_cmd.wr_addr] <= w_vpoke;
        end
        if (i_cmd.rd_en) begin
            r_rd_v <= mem_v[i_cmd.rd_addr];
        end
    end

    // Delta memory, always written in a step before it is read
    always_ff @(posedge i_clk) begin
        if (i_cmd.dw_en) begin
            mem_d[i_cmd.wr_addr] <= sat32(48'(r_acc));
        end
        if (i_cmd.rd_en) begin
            r_rd_d <= mem_d[i_cmd.rd_addr];
        end
    end

    // Arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_cap) begin
            r_amt <= i_amount;
        end
        // difference stage; center slot feeds the restore term
        if (i_cmd.d_en) begin
            r_dc <= i_cmd.d_center;
            if (i_cmd.d_center) begin
                r_hc <= r_rd_h;
                r_vc <= r_rd_v;
                r_dh <= 33'(r_rd_h);
                r_dv <= '0;
            end else begin
                r_dh <= 33'(r_hc) - 33'(r_rd_h);
                r_dv <= 33'(r_vc) - 33'(r_rd_v);
            end
        end
        if (i_cmd.m_en) begin
            r_ph <= r_dh * (r_dc ? i_gains.rg : i_gains.hg);
            r_pv <= r_dv * i_gains.dg;
        end
        if (i_cmd.a_en) begin
            r_acc <= (i_cmd.a_clr ? 42'sd0 : r_acc) + w_term;
        end
        // update pass
        if (i_cmd.u_mul) begin
            r_hc <= r_rd_h;
            r_vc <= r_rd_v;
            r_pd <= r_rd_d * i_gains.ug;
        end
        if (i_cmd.u_vel) begin
            r_vn <= sat32(48'(r_vc) - 48'(rnd12(49'(r_pd))));
        end
    end

    assign o_rd_h = r_rd_h;
    assign o_rd_v = r_rd_v;

endmodule

FILE: rtl/core/sdhf_ctrl.sv
// Controller: clear sweep, two-pass grid sequencer and poke/read access.
module sdhf_ctrl import sdhf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    input  logic [5:0] i_col,
    input  logic [5:0] i_row,
    input  logic       i_out_free,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd,
    output t_ctrl_ev   o_ev
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_PASS1  = 6'b000100,
        S_PASS2  = 6'b001000,
        S_ACCESS = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [3:0]        r_sub, n_sub;
    logic [ADDR_W-1:0] r_node, n_node;
    logic [COL_W-1:0]  r_col, n_col;
    logic [1:0]        r_op, n_op;
    logic              r_rd_ok, n_rd_ok;

    logic              w_accept, w_in_grid, w_last;
    logic [ADDR_W-1:0] w_addr, w_adv_node;
    logic [COL_W-1:0]  w_adv_col;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;
    assign w_in_grid  = (int'(i_col) < GRID_COLS) && (int'(i_row) < GRID_ROWS);
    assign w_addr     = ADDR_W'(int'(i_row) * GRID_COLS + int'(i_col));
    assign w_last     = (r_node == ADDR_W'(LAST_NODE));

    // Next interior node, skipping the border columns
    always_comb begin
        if (r_col == COL_W'(GRID_COLS - 2)) begin
            w_adv_col  = COL_W'(1);
            w_adv_node = r_node + ADDR_W'(3);
        end else begin
            w_adv_col  = r_col + COL_W'(1);
            w_adv_node = r_node + ADDR_W'(1);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_sub   = r_sub;
        n_node  = r_node;
        n_col   = r_col;
        n_op    = r_op;
        n_rd_ok = r_rd_ok;
        case (r_state)
            S_CLEAR: begin
                n_node = r_node + ADDR_W'(1);
                if (r_node == ADDR_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_op;
                    n_sub   = '0;
                    n_rd_ok = 1'b0;
                    if (i_op == OP_STEP) begin
                        n_state = S_PASS1;
                        n_node  = ADDR_W'(FIRST_NODE);
                        n_col   = COL_W'(1);
                    end else if ((i_op == OP_POKE || i_op == OP_READ) && w_in_grid) begin
                        n_state = S_ACCESS;
                        n_node  = w_addr;
                        n_rd_ok = (i_op == OP_READ);
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PASS1: begin
                n_sub = r_sub + 4'd1;
                if (r_sub == 4'd8) begin
                    n_sub = '0;
                    if (w_last) begin
                        n_state = S_PASS2;
                        n_node  = ADDR_W'(FIRST_NODE);
                        n_col   = COL_W'(1);
                    end else begin
                        n_node = w_adv_node;
                        n_col  = w_adv_col;
                    end
                end
            end
            S_PASS2: begin
                n_sub = r_sub + 4'd1;
                if (r_sub == 4'd3) begin
                    n_sub = '0;
                    if (w_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_node = w_adv_node;
                        n_col  = w_adv_col;
                    end
                end
            end
            S_ACCESS: begin
                n_sub = r_sub + 4'd1;
                if (r_sub == 4'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sub   <= '0;
            r_node  <= '0;
            r_col   <= '0;
            r_op    <= OP_POKE;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_node  <= n_node;
            r_col   <= n_col;
            r_op    <= n_op;
            r_rd_ok <= n_rd_ok;
        end
    end

    // Datapath commands from state and sub-cycle
    always_comb begin
        o_cmd         = '0;
        o_cmd.wr_addr = r_node;
        o_cmd.rd_addr = r_node;
        o_cmd.in_cap  = w_accept;
        case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_PASS1: begin
                o_cmd.rd_en    = (r_sub <= 4'd4);
                o_cmd.d_en     = r_sub inside {[4'd1:4'd5]};
                o_cmd.d_center = (r_sub == 4'd1);
                o_cmd.m_en     = r_sub inside {[4'd2:4'd6]};
                o_cmd.a_en     = r_sub inside {[4'd3:4'd7]};
                o_cmd.a_clr    = (r_sub == 4'd3);
                o_cmd.dw_en    = (r_sub == 4'd8);
                case (r_sub)
                    4'd1:    o_cmd.rd_addr = r_node - ADDR_W'(1);
                    4'd2:    o_cmd.rd_addr = r_node + ADDR_W'(1);
                    4'd3:    o_cmd.rd_addr = r_node - ADDR_W'(GRID_COLS);
                    4'd4:    o_cmd.rd_addr = r_node + ADDR_W'(GRID_COLS);
                    default: o_cmd.rd_addr = r_node;
                endcase
            end
            S_PASS2: begin
                o_cmd.rd_en = (r_sub == 4'd0);
                o_cmd.u_mul = (r_sub == 4'd1);
                o_cmd.u_vel = (r_sub == 4'd2);
                o_cmd.u_wr  = (r_sub == 4'd3);
            end
            S_ACCESS: begin
                o_cmd.rd_en = (r_sub == 4'd0);
                o_cmd.pk_wr = (r_sub == 4'd1) && (r_op == OP_POKE);
            end
            default: ;
        endcase
    end

    assign o_ev.done  = (r_state == S_DONE) && i_out_free;
    assign o_ev.rd_ok = r_rd_ok;

    // A result is only handed over when the result register can take it
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev.done |-> i_out_free)
        else $error("result issued while result register busy");

    // The update pass starts at the first interior node
    a_pass2_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_PASS2) |-> (r_node == ADDR_W'(FIRST_NODE)) && (r_sub == 4'd0))
        else $error("update pass did not start at first interior node");

    // Sweeps stay off the border columns
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS1 || r_state == S_PASS2) |->
            (r_col >= COL_W'(1)) && (r_col <= COL_W'(GRID_COLS - 2)))
        else $error("grid sweep reached a border column");

endmodule

FILE: rtl/core/spring_damped_height_field_step.sv
// Top level: stream and register ports, gain registers and result register.
// Spring-damped height field on a 64 x 64 grid of Q16.16 heights and velocities.
// Each input transaction gives exactly one result transaction; only a read
// returns nonzero data. After reset the block sweeps both node memories to zero,
// one node per cycle, and accepts no transaction until done; gain registers can
// be written meanwhile. A step runs two sweeps over the 62 x 62 interior nodes:
// first it fetches each node and its four neighbors through the single memory
// read port and accumulates the delta, then it updates velocity and height of
// each node. A result waiting in the output register does not block acceptance
// of the next transaction.
module spring_damped_height_field_step import sdhf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // col[5:0], row[11:6], amount[43:12], zero pad
    input  logic [1:0]  i_s_tuser,   // op[1:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // height[31:0], speed[63:32]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_gains             r_gains;
    logic               r_out_valid;
    logic [63:0]        r_out_data;
    t_dp_cmd            w_cmd;
    t_ctrl_ev           w_ev;
    logic               w_out_free;
    logic signed [31:0] w_rd_h, w_rd_v;

    assign pready = 1'b1;

    // Gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.hg <= RST_HEIGHT_GAIN;
            r_gains.rg <= RST_RESTORE_GAIN;
            r_gains.dg <= RST_DAMPING_GAIN;
            r_gains.ug <= RST_UPDATE_GAIN;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_HEIGHT_GAIN:  r_gains.hg <= pwdata[15:0];
                REG_RESTORE_GAIN: r_gains.rg <= pwdata[15:0];
                REG_DAMPING_GAIN: r_gains.dg <= pwdata[15:0];
                REG_UPDATE_GAIN:  r_gains.ug <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HEIGHT_GAIN:  prdata = {16'b0, r_gains.hg};
            REG_RESTORE_GAIN: prdata = {16'b0, r_gains.rg};
            REG_DAMPING_GAIN: prdata = {16'b0, r_gains.dg};
            REG_UPDATE_GAIN:  prdata = {16'b0, r_gains.ug};
            default:          prdata = '0;
        endcase
    end

    // Result register
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ev.done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ev.done) begin
            r_out_data <= w_ev.rd_ok ? {w_rd_v, w_rd_h} : 64'd0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    sdhf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .i_col      (i_s_tdata[5:0]),
        .i_row      (i_s_tdata[11:6]),
        .i_out_free (w_out_free),
        .o_in_ready (o_s_tready),
        .o_cmd      (w_cmd),
        .o_ev       (w_ev)
    );

    sdhf_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_gains  (r_gains),
        .i_amount (i_s_tdata[43:12]),
        .o_rd_h   (w_rd_h),
        .o_rd_v   (w_rd_v)
    );

endmodule

FILE: test/tb_top.sv
// Testbench for spring_damped_height_field_step: directed table, random traffic, own grid model.
module tb_top;
    import sdhf_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;   // unused op code
    localparam int INTERIOR_ROWS = GRID_ROWS - 1;
    localparam int INTERIOR_COLS = GRID_COLS - 1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;   // col[5:0], row[11:6], amount[43:12], zero pad
    logic [1:0]  i_s_tuser = '0;   // op[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;        // height[31:0], speed[63:32]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    spring_damped_height_field_step i_dut (.*);

    always #6 i_clk = ~i_clk;

    // Expected node readouts, oldest first
    typedef struct packed {
        logic signed [31:0] height;
        logic signed [31:0] speed;
    } t_node_out;
    t_node_out node_out_q[$];

    // Model of the grid and the gain registers
    logic signed [31:0] grid_h [NODES];
    logic signed [31:0] grid_v [NODES];
    logic signed [31:0] grid_d [NODES];
    longint gain_h, gain_r, gain_d, gain_u;

    int n_items = 0, n_steps = 0, n_results = 0, n_errors = 0;
    bit hold_req = 1'b0;
    bit hold_on = 1'b0;

    function automatic longint scale12(longint p);
        if (p >= 0) return (p + 2048) >>> 12;
        return -((-p + 2048) >>> 12);
    endfunction

    function automatic logic signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic longint spring_term(int a, int b);
        longint dh, dv;
        dh = longint'(grid_h[a]) - longint'(grid_h[b]);
        dv = longint'(grid_v[a]) - longint'(grid_v[b]);
        return scale12(dh * gain_h) + scale12(dv * gain_d);
    endfunction

    // One tick: all deltas from old values, then update interior nodes
    task automatic tick_grid();
        int n;
        longint acc;
        logic signed [31:0] v;
        for (int r = 1; r < INTERIOR_ROWS; r++)
            for (int c = 1; c < INTERIOR_COLS; c++) begin
                n = r * GRID_COLS + c;
                acc = scale12(longint'(grid_h[n]) * gain_r);
                acc += spring_term(n, n - 1) + spring_term(n, n + 1);
                acc += spring_term(n, n - GRID_COLS) + spring_term(n, n + GRID_COLS);
                grid_d[n] = clamp32(acc);
            end
        for (int r = 1; r < INTERIOR_ROWS; r++)
            for (int c = 1; c < INTERIOR_COLS; c++) begin
                n = r * GRID_COLS + c;
                v = clamp32(longint'(grid_v[n]) - scale12(longint'(grid_d[n]) * gain_u));
                grid_v[n] = v;
                grid_h[n] = clamp32(longint'(grid_h[n]) + longint'(v));
                grid_d[n] = '0;
            end
    endtask

    // Apply one command to the model and return the readout it yields
    task automatic apply_cmd(input logic [1:0] op, input logic [5:0] col,
                             input logic [5:0] row, input logic signed [31:0] amt,
                             output t_node_out res);
        int n;
        n = int'(row) * GRID_COLS + int'(col);
        res = '0;
        case (op)
            OP_POKE: grid_v[n] = clamp32(longint'(grid_v[n]) + longint'(amt));
            OP_STEP: tick_grid();
            OP_READ: begin
                res.height = grid_h[n];
                res.speed = grid_v[n];
            end
            default: ;
        endcase
    endtask

    // Register write, setup then access phase
    task automatic write_gain(input logic [1:0] idx, input logic signed [15:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {{16{val[15]}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HEIGHT_GAIN:  gain_h = val;
            REG_RESTORE_GAIN: gain_r = val;
            REG_DAMPING_GAIN: gain_d = val;
            default:          gain_u = val;
        endcase
    endtask

    task automatic write_all_gains(input logic signed [15:0] hg, rg, dg, ug);
        write_gain(REG_HEIGHT_GAIN, hg);
        write_gain(REG_RESTORE_GAIN, rg);
        write_gain(REG_DAMPING_GAIN, dg);
        write_gain(REG_UPDATE_GAIN, ug);
    endtask

    // Offer one transaction; the expectation is queued in acceptance order
    task automatic send_cmd(input logic [1:0] op, input logic [5:0] col,
                            input logic [5:0] row, input logic signed [31:0] amt,
                            input bit typed, input t_node_out typed_res);
        t_node_out res;
        apply_cmd(op, col, row, amt, res);
        node_out_q.push_back(typed ? typed_res : res);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {4'b0, amt, row, col};
        do @(posedge i_clk); while (!o_s_tready);
        n_items++;
        if (op == OP_STEP) n_steps++;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (node_out_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_node_out got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[31:0], o_m_tdata[63:32]};
            n_results++;
            if (node_out_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result h=%h s=%h", got.height, got.speed);
            end else begin
                want = node_out_q.pop_front();
                if (got.height !== want.height || got.speed !== want.speed) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result %0d: exp h=%h s=%h got h=%h s=%h", n_results,
                                 want.height, want.speed, got.height, got.speed);
                end
            end
        end
    end

    // Receiver stall pattern: phases of always ready and of random stalls, or held off on request
    always @(negedge i_clk) begin
        int cyc;
        cyc++;
        if (hold_on) i_m_tready <= 1'b0;
        else if (cyc[6]) i_m_tready <= ($urandom_range(0, 3) != 0);
        else i_m_tready <= 1'b1;
    end

    // Long receiver hold-off while the sender keeps offering
    initial begin
        wait (hold_req);
        @(negedge i_clk);
        hold_on = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_on = 1'b0;
    end

    // Watchdog
    initial begin
        #(12 * 3_000_000);
        $display("spring_damped_height_field_step test failed");
        $finish;
    end

    typedef struct {
        logic [1:0]         op;
        logic [5:0]         col;
        logic [5:0]         row;
        logic signed [31:0] amt;
        bit                 typed;
        t_node_out          res;
    } t_stim_row;

    localparam logic signed [31:0] AMT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] AMT_MIN = 32'sh8000_0000;

    initial begin
        t_stim_row tbl[$];
        logic [1:0] op;
        logic [5:0] col, row;
        logic signed [31:0] amt;
        int k;

        foreach (grid_h[i]) begin
            grid_h[i] = '0;
            grid_v[i] = '0;
            grid_d[i] = '0;
        end
        gain_h = RST_HEIGHT_GAIN;
        gain_r = RST_RESTORE_GAIN;
        gain_d = RST_DAMPING_GAIN;
        gain_u = RST_UPDATE_GAIN;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, reset gains
        tbl = '{
            '{OP_READ, 6'd0, 6'd0, 32'sd0, 1, '0},
            '{OP_READ, 6'd63, 6'd63, 32'sd0, 1, '0},
            '{OP_POKE, 6'd5, 6'd5, AMT_MAX, 1, '0},
            '{OP_POKE, 6'd5, 6'd5, AMT_MAX, 1, '0},
            '{OP_READ, 6'd5, 6'd5, 32'sd0, 1, '{32'sd0, AMT_MAX}},
            '{OP_POKE, 6'd0, 6'd3, AMT_MIN, 1, '0},
            '{OP_POKE, 6'd0, 6'd3, AMT_MIN, 1, '0},
            '{OP_READ, 6'd0, 6'd3, 32'sd0, 1, '{32'sd0, AMT_MIN}},
            '{OP_NONE, 6'd63, 6'd63, 32'sd1, 1, '0},
            '{OP_POKE, 6'd20, 6'd30, 32'sh0001_0000, 1, '0},
            '{OP_POKE, 6'd62, 6'd62, -32'sh0003_0000, 1, '0},
            '{OP_STEP, 6'd0, 6'd0, 32'sd0, 1, '0},
            '{OP_READ, 6'd5, 6'd5, 32'sd0, 0, '0},
            '{OP_READ, 6'd5, 6'd6, 32'sd0, 0, '0},
            '{OP_READ, 6'd0, 6'd3, 32'sd0, 1, '{32'sd0, AMT_MIN}},
            '{OP_READ, 6'd20, 6'd30, 32'sd0, 0, '0},
            '{OP_READ, 6'd62, 6'd62, 32'sd0, 0, '0},
            '{OP_STEP, 6'd0, 6'd0, 32'sd0, 1, '0},
            '{OP_READ, 6'd21, 6'd30, 32'sd0, 0, '0},
            '{OP_READ, 6'd63, 6'd62, 32'sd0, 0, '0},
            '{OP_READ, 6'd4, 6'd5, 32'sd0, 0, '0}
        };
        foreach (tbl[i])
            send_cmd(tbl[i].op, tbl[i].col, tbl[i].row, tbl[i].amt, tbl[i].typed, tbl[i].res);
        drain();

        // Random phases over several gain settings, extremes included
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: write_all_gains(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
                1: write_all_gains(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
                default: write_all_gains(16'($urandom_range(0, 1023)),
                                         16'($urandom_range(0, 255)),
                                         16'($urandom_range(0, 511)),
                                         16'($urandom_range(0, 8191)));
            endcase
            if (phase == 1) hold_req = 1'b1;
            k = 0;
            for (int i = 0; i < 40; i++) begin
                k = $urandom_range(0, 9);
                col = (k < 6) ? 6'($urandom_range(8, 14)) : 6'($urandom_range(0, 63));
                row = (k < 6) ? 6'($urandom_range(8, 14)) : 6'($urandom_range(0, 63));
                case ($urandom_range(0, 3))
                    0: amt = AMT_MAX;
                    1: amt = AMT_MIN;
                    default: amt = $urandom;
                endcase
                if (i == 13 || i == 31) op = OP_STEP;
                else if (k == 9) op = OP_NONE;
                else if (k < 4) op = OP_POKE;
                else op = OP_READ;
                send_cmd(op, col, row, amt, 0, '0);
                if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 12));
            end
            drain();
        end

        $display("covered %0d transactions (%0d steps) and %0d results over 4 gain settings",
                 n_items, n_steps, n_results);
        if (n_errors == 0 && node_out_q.size() == 0)
            $display("spring_damped_height_field_step test passed");
        else
            $display("spring_damped_height_field_step test failed");
        $finish;
    end

endmodule

FILE: spring_damped_height_field_step.f
rtl/core/sdhf_pkg.sv
rtl/core/sdhf_dp.sv
rtl/core/sdhf_ctrl.sv
rtl/core/spring_damped_height_field_step.sv
test/tb_top.sv
